// ===== design/ntps_pkg.sv =====
// ---------------------------------------------------------------------------
// ntps_pkg: shared types and constants for the nearest track point search
// Field widths, request codes, beat structs and reset values used by the
// distance front end, the square-root cells and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package ntps_pkg;

    // Field widths
    localparam int COORD_W       = 20;
    localparam int POINT_W       = 2 * COORD_W;
    localparam int MAX_DIST_W    = 13;
    localparam int FRAC_W        = 8;
    localparam int DIST_W        = 21;
    localparam int MATCH_INDEX_W = 10;
    localparam int SQ_W          = 2 * COORD_W + 2;
    localparam int ROOT_W        = 21;

    // Defaults
    localparam int                    TRACK_DEPTH_DEF = 1024;
    localparam logic [MAX_DIST_W-1:0] MAX_DIST_RESET  = 13'd5000;

    // Request codes (code 3 is unused and ignored)
    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req_type;

    // Input beat
    typedef struct packed {
        logic [1:0]         req_type;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
    } t_req;

    // Result beat
    typedef struct packed {
        logic                     match_found;
        logic [MATCH_INDEX_W-1:0] match_index;
        logic [DIST_W-1:0]        match_distance;
    } t_result;

    // Scan control travelling with a point read
    typedef struct packed {
        logic valid;
        logic last;
    } t_scan_ctl;

    // Beat handed along the square-root chain
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [SQ_W-1:0]   rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_beat;

endpackage

`default_nettype wire

// ===== design/ntps_ram.sv =====
// ---------------------------------------------------------------------------
// ntps_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ntps_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ntps_dist.sv =====
// ---------------------------------------------------------------------------
// ntps_dist: squared distance front end
// Three registered stages: absolute differences, squares, sum. Emits one
// beat into the square-root chain per point read.
// ---------------------------------------------------------------------------
`default_nettype none

module ntps_dist (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ntps_pkg::t_scan_ctl           i_ctl,
    input  wire logic [ntps_pkg::POINT_W-1:0]  i_point,
    input  wire logic [ntps_pkg::COORD_W-1:0]  i_key_x,
    input  wire logic [ntps_pkg::COORD_W-1:0]  i_key_y,
    output ntps_pkg::t_sqrt_beat               o_beat
);

    import ntps_pkg::*;

    t_scan_ctl            r_ctl1;
    t_scan_ctl            r_ctl2;
    logic [COORD_W-1:0]   r_dx;
    logic [COORD_W-1:0]   r_dy;
    logic [2*COORD_W-1:0] r_sqx;
    logic [2*COORD_W-1:0] r_sqy;
    logic [COORD_W-1:0]   w_px;
    logic [COORD_W-1:0]   w_py;
    logic [COORD_W-1:0]   n_dx;
    logic [COORD_W-1:0]   n_dy;

    // Split the stored point: y high, x low
    assign w_px = i_point[COORD_W-1:0];
    assign w_py = i_point[POINT_W-1:COORD_W];

    // Absolute differences
    always_comb begin
        n_dx = (i_key_x >= w_px) ? (i_key_x - w_px) : (w_px - i_key_x);
        n_dy = (i_key_y >= w_py) ? (i_key_y - w_py) : (w_py - i_key_y);
    end

    // Advance payload (differences, squares, sum) and control flags
    always_ff @(posedge i_clk) begin
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_sqx       <= r_dx * r_dx;
        r_sqy       <= r_dy * r_dy;
        o_beat.rem  <= SQ_W'(r_sqx) + SQ_W'(r_sqy);
        o_beat.root <= '0;
        if (!i_rst_n) begin
            r_ctl1       <= '0;
            r_ctl2       <= '0;
            o_beat.valid <= 1'b0;
            o_beat.last  <= 1'b0;
        end else begin
            r_ctl1       <= i_ctl;
            r_ctl2       <= r_ctl1;
            o_beat.valid <= r_ctl2.valid;
            o_beat.last  <= r_ctl2.last;
        end
    end

endmodule

`default_nettype wire

// ===== design/ntps_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// ntps_sqrt_cell: one digit of the pipelined integer square root
// Decides root bit BIT by a trial subtract of the remainder and hands the
// updated remainder and partial root to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module ntps_sqrt_cell #(
    parameter int BIT = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ntps_pkg::t_sqrt_beat i_beat,
    output ntps_pkg::t_sqrt_beat      o_beat
);

    import ntps_pkg::*;

    localparam logic [SQ_W-1:0]   SQ_BIT   = SQ_W'(1) << (2 * BIT);
    localparam logic [ROOT_W-1:0] ROOT_BIT = ROOT_W'(1) << BIT;

    logic [SQ_W-1:0]   w_trial;
    logic              w_fits;
    logic [SQ_W-1:0]   n_rem;
    logic [ROOT_W-1:0] n_root;

    // Trial value (2R + 2^BIT) * 2^BIT; partial root has no bits at or below BIT
    always_comb begin
        w_trial = (SQ_W'(i_beat.root) << (BIT + 1)) | SQ_BIT;
        w_fits  = (i_beat.rem >= w_trial);
        n_rem   = w_fits ? (i_beat.rem - w_trial) : i_beat.rem;
        n_root  = w_fits ? (i_beat.root | ROOT_BIT) : i_beat.root;
    end

    // Advance remainder, root and control flags
    always_ff @(posedge i_clk) begin
        o_beat.rem  <= n_rem;
        o_beat.root <= n_root;
        if (!i_rst_n) begin
            o_beat.valid <= 1'b0;
            o_beat.last  <= 1'b0;
        end else begin
            o_beat.valid <= i_beat.valid;
            o_beat.last  <= i_beat.last;
        end
    end

endmodule

`default_nettype wire

// ===== design/nearest_track_point_search.sv =====
// ---------------------------------------------------------------------------
// nearest_track_point_search: brute-force nearest track point in 2-D
// Keeps a store of Q12.8 track points and answers a query keypoint with the
// nearest stored point and its truncated Euclidean distance in Q13.8.
//
//   channel   handshake            payload        direction
//   request   start / busy         i_req          in
//   result    o_done (strobe)      o_result       out
//   config    i_cfg_we             i_cfg_wdata    in
//
// Append and clear do not raise busy; back-to-back appends are taken.
// A query holds busy while it reads one point from the store RAM per
// cycle and then while the distance stages and the 21-cell square-root
// chain drain. An empty-store query answers in the cycle after it is
// taken, without raising busy. Reset is synchronous, needs no clearing
// pass; a result beat is shown for one cycle and cannot be stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_track_point_search #(
    parameter int TRACK_DEPTH = ntps_pkg::TRACK_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire ntps_pkg::t_req                    i_req,
    output logic                                   o_done,
    output ntps_pkg::t_result                      o_result,
    input  wire logic                              i_cfg_we,
    input  wire logic [ntps_pkg::MAX_DIST_W-1:0]   i_cfg_wdata
);

    import ntps_pkg::*;

    localparam int IDX_W = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
    localparam int CNT_W = $clog2(TRACK_DEPTH + 1);
    localparam int EXT_W = IDX_W + MATCH_INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_count;
    logic [MAX_DIST_W-1:0] r_max_dist;
    logic [IDX_W-1:0]      r_rd_addr;
    t_scan_ctl             r_rd_ctl;
    logic [COORD_W-1:0]    r_key_x;
    logic [COORD_W-1:0]    r_key_y;
    logic [DIST_W-1:0]     r_best;
    logic                  r_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [IDX_W-1:0]      r_arrive_idx;

    logic                  w_accept;
    logic                  w_space;
    logic                  w_ram_we;
    logic                  w_rd_en;
    logic                  w_rd_last;
    logic                  w_empty_ans;
    logic [POINT_W-1:0]    w_rd_data;
    logic                  w_take;
    logic [DIST_W-1:0]     n_best;
    logic                  n_found;
    logic [IDX_W-1:0]      n_best_idx;
    logic [EXT_W-1:0]      w_idx_ext;
    logic [DIST_W-1:0]     w_max_q;
    t_sqrt_beat            w_chain [ROOT_W+1];

    // Handshake and store control
    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign w_space     = (r_count != CNT_W'(TRACK_DEPTH));
    assign w_ram_we    = w_accept && (i_req.req_type == REQ_APPEND) && w_space;
    assign w_rd_en     = (r_state == S_SCAN);
    assign w_rd_last   = w_rd_en && (CNT_W'(r_rd_addr) == (r_count - CNT_W'(1)));
    assign w_empty_ans = w_accept && (i_req.req_type == REQ_QUERY) && (r_count == '0);
    assign w_max_q     = {r_max_dist, FRAC_W'(0)};

    // Track point store
    ntps_ram #(
        .WIDTH (POINT_W),
        .DEPTH (TRACK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata ({i_req.coord_y, i_req.coord_x}),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_addr),
        .o_rdata (w_rd_data)
    );

    // Squared distance stages
    ntps_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_point (w_rd_data),
        .i_key_x (r_key_x),
        .i_key_y (r_key_y),
        .o_beat  (w_chain[0])
    );

    // Square-root chain, most significant root bit first
    for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
        ntps_sqrt_cell #(
            .BIT (ROOT_W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g+1])
        );
    end

    // Keep the nearest so far; equal distance goes to the later point
    always_comb begin
        w_take     = w_chain[ROOT_W].valid && (w_chain[ROOT_W].root <= r_best);
        n_best     = w_take ? w_chain[ROOT_W].root : r_best;
        n_found    = w_take ? 1'b1 : r_found;
        n_best_idx = w_take ? r_arrive_idx : r_best_idx;
        w_idx_ext  = EXT_W'(n_best_idx);
    end

    // State, store count, register and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_max_dist   <= MAX_DIST_RESET;
            r_rd_addr    <= '0;
            r_rd_ctl     <= '0;
            r_key_x      <= '0;
            r_key_y      <= '0;
            r_best       <= '0;
            r_found      <= 1'b0;
            r_best_idx   <= '0;
            r_arrive_idx <= '0;
            o_done       <= 1'b0;
            o_result     <= '0;
        end else begin
            o_done         <= w_empty_ans || (w_chain[ROOT_W].valid && w_chain[ROOT_W].last);
            r_rd_ctl.valid <= w_rd_en;
            r_rd_ctl.last  <= w_rd_last;

            if (i_cfg_we) begin
                r_max_dist <= i_cfg_wdata;
            end
            if (w_ram_we) begin
                r_count <= r_count + CNT_W'(1);
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_req.req_type == REQ_CLEAR)) begin
                        r_count <= '0;
                    end
                    if (w_accept && (i_req.req_type == REQ_QUERY)) begin
                        r_key_x      <= i_req.coord_x;
                        r_key_y      <= i_req.coord_y;
                        r_best       <= w_max_q;
                        r_found      <= 1'b0;
                        r_best_idx   <= '0;
                        r_arrive_idx <= '0;
                        r_rd_addr    <= '0;
                        if (r_count == '0) begin
                            o_result.match_found    <= 1'b0;
                            o_result.match_index    <= '0;
                            o_result.match_distance <= w_max_q;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_addr <= r_rd_addr + IDX_W'(1);
                    if (w_rd_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // wait for the last beat out of the chain
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Fold each finished distance into the running minimum
            if (w_chain[ROOT_W].valid) begin
                r_best       <= n_best;
                r_found      <= n_found;
                r_best_idx   <= n_best_idx;
                r_arrive_idx <= r_arrive_idx + IDX_W'(1);
                if (w_chain[ROOT_W].last) begin
                    o_result.match_found    <= n_found;
                    o_result.match_index    <= w_idx_ext[MATCH_INDEX_W-1:0];
                    o_result.match_distance <= n_best;
                    r_state                 <= S_IDLE;
                end
            end
        end
    end

endmodule

`default_nettype wire
